FILE: src/assert_macros.svh
// Assertion macros shared by the pad port responder RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check sampled on the rising clock, held off while reset is asserted.
`define FPMR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fpmr assertion failed");

// Check sampled on the rising clock, also active during reset.
`define FPMR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("fpmr assertion failed");

`endif

FILE: src/fpmr_pkg.sv
// Package for the pad port responder: mode and operation codes, idle values,
// the item struct and the fixed multitap header table. No dependencies.
`default_nettype none

package fpmr_pkg;

    localparam int PAD_COUNT_DEF = 4;
    localparam int PAD_MAX       = 4;

    // pad_mode register codes
    localparam logic [1:0] MODE_THREE = 2'd0;
    localparam logic [1:0] MODE_SIX   = 2'd1;
    localparam logic [1:0] MODE_TAP   = 2'd2;

    // operation codes
    localparam logic OP_PIN     = 1'b0;
    localparam logic OP_BUTTONS = 1'b1;

    localparam logic [3:0] NIB_IDLE  = 4'hf;
    localparam logic [5:0] SOLO_IDLE = 6'h3f;

    typedef struct packed {
        logic                        operation;
        logic                        th_level;
        logic                        tr_level;
        logic                        th_changed;
        logic                        tr_changed;
        logic [3:0]                  changed_mask;
        logic [PAD_MAX-1:0][7:0]     buttons;
    } item_t;

    typedef struct packed {
        logic       hit;
        logic [5:0] data;
    } result_t;

    // Multitap slots 0..7: header and pad type nibbles.
    function automatic logic [3:0] head_slot(input logic [2:0] idx);
        logic [3:0] val;
        case (idx)
            3'd0:    val = 4'h3;
            3'd1:    val = 4'hf;
            default: val = 4'h0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

FILE: src/fpmr_engine.sv
// Responder state (mode, button encodings, multitap index) and the
// single-pass item logic. Depends on fpmr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fpmr_engine #(
    parameter int PAD_COUNT = fpmr_pkg::PAD_COUNT_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_wdata,
    input  wire logic             fire,
    input  wire fpmr_pkg::item_t  item,
    output fpmr_pkg::result_t     res
);
    import fpmr_pkg::*;

    localparam int NIB_DEPTH = 2 * PAD_COUNT;

    logic [1:0] mode_reg;
    logic [3:0] nib_reg [NIB_DEPTH];
    logic [3:0] nib_next [NIB_DEPTH];
    logic [5:0] solo_lo_reg, solo_lo_next;
    logic [5:0] solo_hi_reg, solo_hi_next;
    logic [3:0] idx_reg, idx_next;
    logic       seen_reg, seen_next;

    logic       any_edge;
    logic [3:0] idx_a, idx_b;
    logic       seen_a, adv;
    logic [3:0] slot_val;
    logic [7:0] inv0;

    // multitap sequence walk
    always_comb
    begin
        any_edge = item.th_changed | item.tr_changed;
        idx_a    = item.th_changed ? {3'b000, ~item.th_level} : idx_reg;
        seen_a   = item.th_changed ? item.th_level : seen_reg;
        adv      = item.tr_changed & ~seen_a;
        idx_b    = adv ? idx_a + 4'd1 : idx_a;
    end

    // slot read: fixed header below 8, stored nibbles from 8 up, absent pads idle
    always_comb
    begin
        if (!idx_b[3])
        begin
            slot_val = head_slot(idx_b[2:0]);
        end
        else
        begin
            slot_val = NIB_IDLE;
            for (int k = 0; k < NIB_DEPTH; k++)
            begin
                if (idx_b[2:0] == 3'(k))
                begin
                    slot_val = nib_reg[k];
                end
            end
        end
    end

    always_comb
    begin
        res.hit  = 1'b0;
        res.data = '0;
        if (item.operation == OP_PIN)
        begin
            if (mode_reg == MODE_TAP)
            begin
                res.hit  = item.th_changed | adv;
                res.data = {1'b0, item.tr_level, slot_val};
            end
            else
            begin
                res.hit  = any_edge;
                res.data = item.th_level ? solo_hi_reg : solo_lo_reg;
            end
        end
    end

    assign inv0 = ~item.buttons[0];

    always_comb
    begin
        nib_next     = nib_reg;
        solo_lo_next = solo_lo_reg;
        solo_hi_next = solo_hi_reg;
        idx_next     = idx_reg;
        seen_next    = seen_reg;
        if (fire)
        begin
            if (item.operation == OP_BUTTONS)
            begin
                if (mode_reg == MODE_THREE && item.changed_mask[0])
                begin
                    solo_hi_next = inv0[5:0];
                    solo_lo_next = {inv0[7:6], 2'b00, inv0[1:0]};
                end
                else if (mode_reg == MODE_TAP)
                begin
                    for (int p = 0; p < PAD_COUNT; p++)
                    begin
                        if (item.changed_mask[p])
                        begin
                            nib_next[2*p]   = ~item.buttons[p][3:0];
                            nib_next[2*p+1] = ~item.buttons[p][7:4];
                        end
                    end
                end
            end
            else if (mode_reg == MODE_TAP && any_edge)
            begin
                idx_next  = idx_b;
                seen_next = seen_a;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_THREE;
            solo_lo_reg <= SOLO_IDLE;
            solo_hi_reg <= SOLO_IDLE;
            idx_reg     <= '0;
            seen_reg    <= 1'b1;
            for (int k = 0; k < NIB_DEPTH; k++)
            begin
                nib_reg[k] <= NIB_IDLE;
            end
        end
        else if (cfg_we)
        begin
            // mode write restarts everything, TH taken as idle high
            mode_reg    <= cfg_wdata;
            solo_lo_reg <= SOLO_IDLE;
            solo_hi_reg <= SOLO_IDLE;
            idx_reg     <= '0;
            seen_reg    <= 1'b1;
            for (int k = 0; k < NIB_DEPTH; k++)
            begin
                nib_reg[k] <= NIB_IDLE;
            end
        end
        else
        begin
            solo_lo_reg <= solo_lo_next;
            solo_hi_reg <= solo_hi_next;
            idx_reg     <= idx_next;
            seen_reg    <= seen_next;
            for (int k = 0; k < NIB_DEPTH; k++)
            begin
                nib_reg[k] <= nib_next[k];
            end
        end
    end

    `FPMR_ASSERT(a_update_silent, clk, rst_n, res.hit |-> (item.operation == OP_PIN))
    `FPMR_ASSERT(a_th_restart, clk, rst_n,
        (fire && !cfg_we && item.operation == OP_PIN && mode_reg == MODE_TAP
         && item.th_changed) |=> (idx_reg <= 4'd2))
    `FPMR_ASSERT(a_low_bits_hold, clk, rst_n,
        (mode_reg != MODE_THREE && !cfg_we) |=> $stable(solo_lo_reg))

endmodule

`default_nettype wire

FILE: src/four_pad_multitap_responder_core.sv
// Top level of the pad port responder: input stage, result stage, handshake.
// Depends on fpmr_pkg, fpmr_engine and assert_macros.svh.
//
// Usage:
//  - Input channel (in_valid / in_stall): one beat is either a pin change
//    (operation 0: TH/TR levels and edge flags) or a button update
//    (operation 1: changed_mask and four active-high button bytes).
//  - Output channel (out_valid / out_stall): one beat carries port_data, the
//    last value driven on the six data pins for a pin change. Button
//    updates and pin changes that drive nothing produce no beat.
//  - Config: cfg_we writes pad_mode from cfg_wdata and clears
//    all stored state; write only while the block is idle.
//  - Flow: an accepted beat is registered, evaluated in one
//    pass and lands in the output register.
//  - Throughput: one beat per cycle unless out_stall holds a result, set by
//    the single pass between the input register and the output register.
//  - Stall: while a result sits in the output register and out_stall is
//    high, the input register still takes one beat, then in_stall rises.
//  - Reset: three-button mode, all buttons released, TH idle high, both
//    stages empty.
`default_nettype none
`include "assert_macros.svh"

module four_pad_multitap_responder_core #(
    parameter int PAD_COUNT = fpmr_pkg::PAD_COUNT_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_wdata,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       operation,
    input  wire logic       th_level,
    input  wire logic       tr_level,
    input  wire logic       th_changed,
    input  wire logic       tr_changed,
    input  wire logic [3:0] changed_mask,
    input  wire logic [7:0] buttons_pad0,
    input  wire logic [7:0] buttons_pad1,
    input  wire logic [7:0] buttons_pad2,
    input  wire logic [7:0] buttons_pad3,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [5:0]      port_data
);
    import fpmr_pkg::*;

    item_t      stage_item_reg;
    logic       stage_valid_reg, stage_valid_next;
    logic       out_valid_reg, out_valid_next;
    logic [5:0] out_data_reg;
    logic       advance, stage_fire, in_accept;
    item_t      in_item;
    result_t    res;

    // the stage moves on unless a held result blocks the output register
    assign advance    = !(out_valid_reg && out_stall);
    assign stage_fire = stage_valid_reg && advance;
    assign in_stall   = stage_valid_reg && !advance;
    assign in_accept  = in_valid && !in_stall;

    always_comb
    begin
        in_item.operation    = operation;
        in_item.th_level     = th_level;
        in_item.tr_level     = tr_level;
        in_item.th_changed   = th_changed;
        in_item.tr_changed   = tr_changed;
        in_item.changed_mask = changed_mask;
        in_item.buttons[0]   = buttons_pad0;
        in_item.buttons[1]   = buttons_pad1;
        in_item.buttons[2]   = buttons_pad2;
        in_item.buttons[3]   = buttons_pad3;
    end

    always_comb
    begin
        if (in_accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (stage_fire)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
        out_valid_next = stage_fire ? res.hit : (out_valid_reg && out_stall);
    end

    fpmr_engine #(
        .PAD_COUNT (PAD_COUNT)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (stage_fire),
        .item      (stage_item_reg),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stage_item_reg <= in_item;
        end
        if (stage_fire && res.hit)
        begin
            out_data_reg <= res.data;
        end
    end

    assign out_valid = out_valid_reg;
    assign port_data = out_data_reg;

    `FPMR_ASSERT(a_stage_held, clk, rst_n,
        (stage_valid_reg && out_valid_reg && out_stall) |=> stage_valid_reg)
    `FPMR_ASSERT(a_result_source, clk, rst_n,
        $rose(out_valid_reg) |-> $past(stage_fire))
    `FPMR_ASSERT_ALWAYS(a_reset_empty, clk,
        !rst_n |=> (!out_valid_reg && !stage_valid_reg))

endmodule

`default_nettype wire
